### sv/fsr_pkg.sv
// Shared types and constants for the fraction sum reduction block.
// Depends on nothing; fraction_sum_reduce refers to it by scoped names.
`timescale 1ns / 1ps

package fsr_pkg;

    // Result field widths are fixed by the output format.
    localparam int OUT_NUM_W  = 64;
    localparam int OUT_DEN_W  = 63;

    // Shared multiplier: one 32x32 unsigned product per cycle in the ST_MUL_LO and ST_MUL_HI states.
    localparam int MUL_HALF_W = 32;
    localparam int MUL_PAD_W  = 2 * MUL_HALF_W;
    localparam int PROD_W     = MUL_PAD_W + MUL_HALF_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_ADD,
        ST_MUL_FIN,
        ST_SUM,
        ST_CHK,
        ST_GCD,
        ST_DIV,
        ST_OUT
    } t_state;

    // Which of the three products of one fraction is in the multiplier.
    typedef enum logic [1:0] {
        OP_BN,   // running denominator times numerator
        OP_AD,   // running numerator times denominator
        OP_BD    // running denominator times denominator
    } t_mul_op;

endpackage

### sv/fraction_sum_reduce.sv
// Running sum of signed fractions, reduced to lowest terms at the end of each sum.
// Depends on fsr_pkg (state and operation codes, multiplier and result widths).
`timescale 1ns / 1ps

// fraction_sum_reduce keeps a running sum a/b (reset to 0/1) and adds one
// signed fraction n/d per request: a = n*b + a*d, b = b*d, wrapping in
// ACC_WIDTH-bit two's complement, with a sticky overflow flag. A request
// marked last_item ends the sum: the block finds the greatest common divisor
// of |a| and |b| by binary subtract-and-halve steps, divides both by it,
// moves the sign into the numerator and emits one result, then restarts at
// 0/1. A zero running denominator gives 0/0 with zero_denominator set; a zero
// numerator gives 0/1. Only the last request of a sum produces a result.
// Flow: the block works on one request at a time and holds o_in_stall high
// until it is done. A request that is not last is accepted, then passes
// three products through one shared 32x32 multiplier (states ST_MUL_LO,
// ST_MUL_HI, ST_MUL_ADD, ST_MUL_FIN for each), then one add. A last request
// adds a check state, then a data-dependent divisor search (one subtract,
// halve or swap per cycle), then two restoring divisions on the same
// subtractor, then loads the output register once it is free.
// The result sits in its own register, so a waiting result does not block
// the next sum until that sum is finished as well.
module fraction_sum_reduce #(
    parameter int INPUT_WIDTH = 16,
    parameter int ACC_WIDTH   = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // request channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [INPUT_WIDTH-1:0]         i_numerator,
    input  logic signed [INPUT_WIDTH-1:0]         i_denominator,
    input  logic                                  i_last_item,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [fsr_pkg::OUT_NUM_W-1:0]  o_sum_numerator,
    output logic        [fsr_pkg::OUT_DEN_W-1:0]  o_sum_denominator,
    output logic                                  o_overflowed,
    output logic                                  o_zero_denominator
);

    localparam int AW    = ACC_WIDTH;
    localparam int IW    = INPUT_WIDTH;
    localparam int HW    = fsr_pkg::MUL_HALF_W;
    localparam int XW    = fsr_pkg::MUL_PAD_W;
    localparam int PW    = fsr_pkg::PROD_W;
    localparam int NW    = fsr_pkg::OUT_NUM_W;
    localparam int DW    = fsr_pkg::OUT_DEN_W;
    localparam int CNT_W = $clog2(ACC_WIDTH);

    // Magnitude of the most negative accumulator value; a positive product
    // may reach one less.
    localparam logic [PW-1:0] MIN_MAG = {{(PW-1){1'b0}}, 1'b1} << (AW - 1);

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    fsr_pkg::t_state  r_state,  n_state;
    fsr_pkg::t_mul_op r_op,     n_op;

    logic [AW-1:0]    r_a,      n_a;       // running numerator
    logic [AW-1:0]    r_b,      n_b;       // running denominator
    logic             r_ovf,    n_ovf;     // sticky overflow
    logic [AW-1:0]    r_t1,     n_t1;      // first product of the numerator

    logic [HW-1:0]    r_nm,     n_nm;      // |n|
    logic [HW-1:0]    r_dm,     n_dm;      // |d|
    logic             r_nsg,    n_nsg;
    logic             r_dsg,    n_dsg;
    logic             r_asg,    n_asg;
    logic             r_bsg,    n_bsg;
    logic             r_last,   n_last;

    logic [AW-1:0]    r_am,     n_am;      // |a|, later reduced numerator
    logic [AW-1:0]    r_bm,     n_bm;      // |b|, later reduced denominator
    logic [XW-1:0]    r_pp,     n_pp;      // partial product
    logic [PW-1:0]    r_prod,   n_prod;    // full product magnitude

    logic [AW-1:0]    r_gx,     n_gx;      // divisor search operands
    logic [AW-1:0]    r_gy,     n_gy;
    logic [AW-1:0]    r_rem,    n_rem;     // divider remainder
    logic [AW-1:0]    r_quo,    n_quo;     // dividend in, quotient out
    logic [CNT_W-1:0] r_cnt,    n_cnt;
    logic             r_dsel,   n_dsel;    // second division running
    logic             r_neg,    n_neg;     // sign of the reduced sum
    logic             r_zden,   n_zden;

    logic             r_out_valid, n_out_valid;
    logic [NW-1:0]    r_out_num,   n_out_num;
    logic [DW-1:0]    r_out_den,   n_out_den;
    logic             r_out_ovf,   n_out_ovf;
    logic             r_out_zden,  n_out_zden;

    // ---------------------------------------------------------------------
    // Combinational helpers
    // ---------------------------------------------------------------------
    logic [IW-1:0] num_u;
    logic [IW-1:0] den_u;
    logic [IW-1:0] num_mag;
    logic [IW-1:0] den_mag;
    logic [AW-1:0] a_mag;
    logic [AW-1:0] b_mag;

    logic          in_take;
    logic          out_free;

    // shared multiplier
    logic          mul_xn;
    logic          mul_yn;
    logic [AW-1:0] mul_xmag;
    logic [XW-1:0] mul_xpad;
    logic [HW-1:0] mul_x;
    logic [HW-1:0] mul_y;
    logic          mul_neg;
    logic [PW-1:0] mul_limit;
    logic          mul_ovf;
    logic [AW-1:0] mul_lo;
    logic [AW-1:0] mul_res;

    // accumulator add
    logic [AW-1:0] sum_ab;
    logic          sum_ovf;

    // shared subtractor for divisor search and division
    logic [AW:0]   sub_a;
    logic [AW:0]   sub_b;
    logic [AW:0]   sub_d;
    logic          sub_borrow;
    logic          div_bit;
    logic [AW-1:0] div_rem;
    logic [AW-1:0] div_quo;

    // result formatting
    logic [NW-1:0] fin_num;
    logic [NW-1:0] fin_den;

    assign num_u   = i_numerator;
    assign den_u   = i_denominator;
    assign num_mag = num_u[IW-1] ? (~num_u + IW'(1)) : num_u;
    assign den_mag = den_u[IW-1] ? (~den_u + IW'(1)) : den_u;
    assign a_mag   = r_a[AW-1] ? (~r_a + AW'(1)) : r_a;
    assign b_mag   = r_b[AW-1] ? (~r_b + AW'(1)) : r_b;

    assign in_take  = i_in_valid && (r_state == fsr_pkg::ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // Operand selection for the product in flight.
    assign mul_xn   = (r_op == fsr_pkg::OP_AD) ? r_asg : r_bsg;
    assign mul_yn   = (r_op == fsr_pkg::OP_BN) ? r_nsg : r_dsg;
    assign mul_xmag = (r_op == fsr_pkg::OP_AD) ? r_am  : r_bm;
    assign mul_xpad = XW'(mul_xmag);
    assign mul_x    = (r_state == fsr_pkg::ST_MUL_HI) ? mul_xpad[XW-1:HW] : mul_xpad[HW-1:0];
    assign mul_y    = (r_op == fsr_pkg::OP_BN) ? r_nm : r_dm;

    // Wrap and overflow of a finished product.
    assign mul_neg   = (mul_xn != mul_yn) && (r_prod != '0);
    assign mul_limit = mul_neg ? MIN_MAG : (MIN_MAG - PW'(1));
    assign mul_ovf   = r_prod > mul_limit;
    assign mul_lo    = r_prod[AW-1:0];
    assign mul_res   = mul_neg ? (~mul_lo + AW'(1)) : mul_lo;

    assign sum_ab  = r_t1 + r_a;
    assign sum_ovf = (r_t1[AW-1] == r_a[AW-1]) && (sum_ab[AW-1] != r_a[AW-1]);

    always_comb begin
        if (r_state == fsr_pkg::ST_DIV) begin
            sub_a = {r_rem, r_quo[AW-1]};
        end else begin
            sub_a = {1'b0, r_gx};
        end
        if (r_state == fsr_pkg::ST_DIV) begin
            sub_b = {1'b0, r_gx};
        end else begin
            sub_b = {1'b0, r_gy};
        end
    end

    assign sub_d      = sub_a - sub_b;
    assign sub_borrow = sub_d[AW];
    assign div_bit    = !sub_borrow;
    assign div_rem    = sub_borrow ? sub_a[AW-1:0] : sub_d[AW-1:0];
    assign div_quo    = {r_quo[AW-2:0], div_bit};

    assign fin_num = NW'(r_am);
    assign fin_den = NW'(r_bm);

    // ---------------------------------------------------------------------
    // Sequencer: next state and datapath
    // ---------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_a         = r_a;
        n_b         = r_b;
        n_ovf       = r_ovf;
        n_t1        = r_t1;
        n_nm        = r_nm;
        n_dm        = r_dm;
        n_nsg       = r_nsg;
        n_dsg       = r_dsg;
        n_asg       = r_asg;
        n_bsg       = r_bsg;
        n_last      = r_last;
        n_am        = r_am;
        n_bm        = r_bm;
        n_pp        = r_pp;
        n_prod      = r_prod;
        n_gx        = r_gx;
        n_gy        = r_gy;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_dsel      = r_dsel;
        n_neg       = r_neg;
        n_zden      = r_zden;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_num   = r_out_num;
        n_out_den   = r_out_den;
        n_out_ovf   = r_out_ovf;
        n_out_zden  = r_out_zden;

        case (r_state)
            fsr_pkg::ST_IDLE: begin
                // Latch the request with operand magnitudes and signs.
                if (in_take) begin
                    n_nm    = HW'(num_mag);
                    n_dm    = HW'(den_mag);
                    n_nsg   = num_u[IW-1];
                    n_dsg   = den_u[IW-1];
                    n_am    = a_mag;
                    n_bm    = b_mag;
                    n_asg   = r_a[AW-1];
                    n_bsg   = r_b[AW-1];
                    n_last  = i_last_item;
                    n_op    = fsr_pkg::OP_BN;
                    n_state = fsr_pkg::ST_MUL_LO;
                end
            end

            fsr_pkg::ST_MUL_LO: begin
                n_pp    = XW'(mul_x) * XW'(mul_y);
                n_state = fsr_pkg::ST_MUL_HI;
            end

            fsr_pkg::ST_MUL_HI: begin
                n_prod  = PW'(r_pp);
                n_pp    = XW'(mul_x) * XW'(mul_y);
                n_state = fsr_pkg::ST_MUL_ADD;
            end

            fsr_pkg::ST_MUL_ADD: begin
                n_prod  = r_prod + (PW'(r_pp) << HW);
                n_state = fsr_pkg::ST_MUL_FIN;
            end

            fsr_pkg::ST_MUL_FIN: begin
                // Wrap the product into r_t1, r_a or r_b and move on to the next product or the add.
                n_ovf = r_ovf || mul_ovf;
                case (r_op)
                    fsr_pkg::OP_BN: begin
                        n_t1    = mul_res;
                        n_op    = fsr_pkg::OP_AD;
                        n_state = fsr_pkg::ST_MUL_LO;
                    end
                    fsr_pkg::OP_AD: begin
                        n_a     = mul_res;
                        n_op    = fsr_pkg::OP_BD;
                        n_state = fsr_pkg::ST_MUL_LO;
                    end
                    fsr_pkg::OP_BD: begin
                        n_b     = mul_res;
                        n_state = fsr_pkg::ST_SUM;
                    end
                    default: begin
                        n_state = fsr_pkg::ST_IDLE;
                    end
                endcase
            end

            fsr_pkg::ST_SUM: begin
                n_a     = sum_ab;
                n_ovf   = r_ovf || sum_ovf;
                n_state = r_last ? fsr_pkg::ST_CHK : fsr_pkg::ST_IDLE;
            end

            fsr_pkg::ST_CHK: begin
                n_zden = 1'b0;
                n_neg  = 1'b0;
                if (r_b == '0) begin
                    // undefined sum: report 0/0
                    n_zden  = 1'b1;
                    n_am    = '0;
                    n_bm    = '0;
                    n_state = fsr_pkg::ST_OUT;
                end else if (r_a == '0) begin
                    n_am    = '0;
                    n_bm    = AW'(1);
                    n_state = fsr_pkg::ST_OUT;
                end else begin
                    n_neg   = r_a[AW-1] != r_b[AW-1];
                    n_am    = a_mag;
                    n_bm    = b_mag;
                    n_gx    = a_mag;
                    n_gy    = b_mag;
                    n_state = fsr_pkg::ST_GCD;
                end
            end

            fsr_pkg::ST_GCD: begin
                // Binary divisor search. Common factors of two are stripped
                // from the dividends as well, so the odd part left in r_gx
                // divides them exactly.
                if (sub_d == '0) begin
                    n_rem   = '0;
                    n_quo   = r_am;
                    n_cnt   = CNT_W'(AW - 1);
                    n_dsel  = 1'b0;
                    n_state = fsr_pkg::ST_DIV;
                end else if (!r_gx[0] && !r_gy[0]) begin
                    n_gx = r_gx >> 1;
                    n_gy = r_gy >> 1;
                    n_am = r_am >> 1;
                    n_bm = r_bm >> 1;
                end else if (!r_gx[0]) begin
                    n_gx = r_gx >> 1;
                end else if (!r_gy[0]) begin
                    n_gy = r_gy >> 1;
                end else if (sub_borrow) begin
                    n_gx = r_gy;
                    n_gy = r_gx;
                end else begin
                    n_gx = sub_d[AW-1:0];
                end
            end

            fsr_pkg::ST_DIV: begin
                // Restoring division, one quotient bit per cycle.
                n_rem = div_rem;
                n_quo = div_quo;
                if (r_cnt == '0) begin
                    if (!r_dsel) begin
                        n_am   = div_quo;
                        n_quo  = r_bm;
                        n_rem  = '0;
                        n_cnt  = CNT_W'(AW - 1);
                        n_dsel = 1'b1;
                    end else begin
                        n_bm    = div_quo;
                        n_state = fsr_pkg::ST_OUT;
                    end
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end

            fsr_pkg::ST_OUT: begin
                // Hold until the result register is free, then restart at 0/1.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_num   = r_neg ? (~fin_num + NW'(1)) : fin_num;
                    n_out_den   = fin_den[DW-1:0];
                    n_out_ovf   = r_ovf || (!r_neg && fin_num[NW-1]) || fin_den[NW-1];
                    n_out_zden  = r_zden;
                    n_a         = '0;
                    n_b         = AW'(1);
                    n_ovf       = 1'b0;
                    n_state     = fsr_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = fsr_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state and accumulator, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fsr_pkg::ST_IDLE;
            r_a         <= '0;
            r_b         <= AW'(1);
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_a         <= n_a;
            r_b         <= n_b;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_t1       <= n_t1;
        r_nm       <= n_nm;
        r_dm       <= n_dm;
        r_nsg      <= n_nsg;
        r_dsg      <= n_dsg;
        r_asg      <= n_asg;
        r_bsg      <= n_bsg;
        r_last     <= n_last;
        r_am       <= n_am;
        r_bm       <= n_bm;
        r_pp       <= n_pp;
        r_prod     <= n_prod;
        r_gx       <= n_gx;
        r_gy       <= n_gy;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_dsel     <= n_dsel;
        r_neg      <= n_neg;
        r_zden     <= n_zden;
        r_out_num  <= n_out_num;
        r_out_den  <= n_out_den;
        r_out_ovf  <= n_out_ovf;
        r_out_zden <= n_out_zden;
    end

    assign o_in_stall         = (r_state != fsr_pkg::ST_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_sum_numerator    = r_out_num;
    assign o_sum_denominator  = r_out_den;
    assign o_overflowed       = r_out_ovf;
    assign o_zero_denominator = r_out_zden;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fsr_pkg::ST_GCD) |-> (r_gx != '0 && r_gy != '0))
        else $error("divisor search operand reached zero");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fsr_pkg::ST_DIV) |-> (r_gx != '0))
        else $error("division by zero divisor");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fsr_pkg::ST_OUT && out_free) |=>
        (r_a == '0 && r_b == AW'(1) && !r_ovf && o_out_valid))
        else $error("sum not restarted at 0/1 after emitting a result");

    a_zero_den_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_zero_denominator) |->
        (o_sum_numerator == '0 && o_sum_denominator == '0))
        else $error("undefined sum not reported as 0/0");

    a_ready_after_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fsr_pkg::ST_SUM && !r_last) |=> !o_in_stall)
        else $error("block not ready after a non-final request");

endmodule
